// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked property, disabled while reset is asserted
`define FDP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fdp assertion failed");

// a stalled valid stays up and its payload signal holds
`define FDP_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> (vld && $stable(sig))) \
    else $error("fdp stalled transaction changed");

`endif

// ===== hdl/fdp_pkg.sv =====
`timescale 1ns / 1ps
package fdp_pkg;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned THR_W    = LIMIT_W + DATA_W + 1;

  typedef enum logic [2:0] {
    REG_UNTHROTTLED = 3'd0,
    REG_PERIOD      = 3'd1,
    REG_REM_STEP    = 3'd2,
    REG_REM_MOD     = 3'd3,
    REG_LATE_LIMIT  = 3'd4
  } reg_idx_e;

  localparam logic [DATA_W-1:0]  RST_PERIOD     = 32'd16688154;
  localparam logic [DATA_W-1:0]  RST_REM_STEP   = 32'd26851050;
  localparam logic [DATA_W-1:0]  RST_REM_MOD    = 32'd53693175;
  localparam logic [LIMIT_W-1:0] RST_LATE_LIMIT = 8'd4;
  localparam logic [THR_W-1:0]   RST_THRESHOLD  =
    THR_W'(RST_LATE_LIMIT) * (THR_W'(RST_PERIOD) + THR_W'(1));

endpackage

// ===== hdl/frame_deadline_pacer_top.sv =====
`timescale 1ns / 1ps
// frame deadline pacer
// input channel: one transaction per frame-ready event, carrying now_ns_i
//   (in_valid_i / in_stall_o). output channel: one transaction per event with
//   status, wait_ns, resynced and the two running totals (out_valid_o /
//   out_stall_i).
// the deadline advances by period_whole_ns plus a fractional carry each event
//   that is not backwards; the late threshold late_limit_periods * (period + 1)
//   is kept in a register that is refreshed on the apb write itself.
// an accepted input transaction is loaded into the input register; its result
//   is loaded into the result register when the input register advances.
// throughput: one event per cycle when not stalled; the deadline/fraction update is
//   a single pass of compare, select and add between the input and result registers.
// when the receiver stalls, the result register holds and the input register
//   still takes one more event; beyond that in_stall_o is raised.
// reset clears the pacer state (not started, counters zero) and loads the
//   default period registers; no transaction is presented after reset.
// configuration is written through the apb port, the user must do so only while no event is in flight (not enforced).
module frame_deadline_pacer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdp_pkg::ADDR_W-1:0]  paddr,
  input  logic [fdp_pkg::DATA_W-1:0]  pwdata,
  output logic [fdp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fdp_pkg::TIME_W-1:0]  now_ns_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [fdp_pkg::TIME_W-1:0]  wait_ns_o,
  output logic                        resynced_o,
  output logic [fdp_pkg::CNT_W-1:0]   resync_total_o,
  output logic [fdp_pkg::CNT_W-1:0]   wait_total_o
);
  import fdp_pkg::*;

  // configuration registers
  logic               unthr_q;
  logic [DATA_W-1:0]  period_q;
  logic [DATA_W-1:0]  step_q;
  logic [DATA_W-1:0]  mod_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [THR_W-1:0]   thr_q, thr_d;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  // pacer state
  logic               started_q;
  logic [TIME_W-1:0]  deadline_q, deadline_d;
  logic [TIME_W-1:0]  last_q;
  logic [DATA_W-1:0]  frac_q, frac_d;
  logic [CNT_W-1:0]   resync_cnt_q, resync_cnt_d;
  logic [CNT_W-1:0]   wait_cnt_q, wait_cnt_d;

  // input register
  logic               s1_valid_q;
  logic [TIME_W-1:0]  s1_now_q;
  logic               s1_adv, s1_fire, in_fire;

  // result register
  logic               out_valid_q;
  logic               status_q;
  logic [TIME_W-1:0]  wait_q;
  logic               resynced_q;
  logic [CNT_W-1:0]   resync_tot_q;
  logic [CNT_W-1:0]   wait_tot_q;

  // datapath
  logic               backwards, late, rebase, need_wait, carry;
  logic [TIME_W-1:0]  gap, base_dl, wait_val;
  logic [DATA_W-1:0]  base_frac;
  logic [DATA_W:0]    frac_sum;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_UNTHROTTLED: prdata = {{(DATA_W-1){1'b0}}, unthr_q};
      REG_PERIOD:      prdata = period_q;
      REG_REM_STEP:    prdata = step_q;
      REG_REM_MOD:     prdata = mod_q;
      REG_LATE_LIMIT:  prdata = {{(DATA_W-LIMIT_W){1'b0}}, limit_q};
      default:         prdata = '0;
    endcase
  end

  // threshold follows whichever operand is being written
  always_comb begin
    thr_d = thr_q;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_PERIOD:     thr_d = THR_W'(limit_q) * (THR_W'(pwdata) + THR_W'(1));
        REG_LATE_LIMIT: thr_d = THR_W'(pwdata[LIMIT_W-1:0]) *
                                (THR_W'(period_q) + THR_W'(1));
        default:        thr_d = thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unthr_q  <= 1'b0;
      period_q <= RST_PERIOD;
      step_q   <= RST_REM_STEP;
      mod_q    <= RST_REM_MOD;
      limit_q  <= RST_LATE_LIMIT;
      thr_q    <= RST_THRESHOLD;
    end else begin
      thr_q <= thr_d;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_UNTHROTTLED: unthr_q  <= pwdata[0];
          REG_PERIOD:      period_q <= pwdata;
          REG_REM_STEP:    step_q   <= pwdata;
          REG_REM_MOD:     mod_q    <= pwdata;
          REG_LATE_LIMIT:  limit_q  <= pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // handshake
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_now_q <= now_ns_i;
    end
  end

  // per-event update
  always_comb begin
    backwards = started_q && (s1_now_q < last_q);
    gap       = s1_now_q - deadline_q;
    late      = started_q && (s1_now_q > deadline_q) &&
                (gap > TIME_W'(thr_q));
    rebase    = !started_q || late;
    base_dl   = rebase ? s1_now_q : deadline_q;
    base_frac = rebase ? '0 : frac_q;
    need_wait = !unthr_q && (s1_now_q < base_dl);
    wait_val  = need_wait ? (base_dl - s1_now_q) : '0;
    frac_sum  = {1'b0, base_frac} + {1'b0, step_q};
    carry     = frac_sum >= {1'b0, mod_q};
    frac_d    = carry ? DATA_W'(frac_sum - {1'b0, mod_q}) : frac_sum[DATA_W-1:0];
    deadline_d   = base_dl + TIME_W'(period_q) + TIME_W'(carry);
    resync_cnt_d = resync_cnt_q + CNT_W'(late);
    wait_cnt_d   = wait_cnt_q + CNT_W'(need_wait);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      deadline_q   <= '0;
      last_q       <= '0;
      frac_q       <= '0;
      resync_cnt_q <= '0;
      wait_cnt_q   <= '0;
    end else if (s1_fire && !backwards) begin
      started_q    <= 1'b1;
      deadline_q   <= deadline_d;
      last_q       <= s1_now_q;
      frac_q       <= frac_d;
      resync_cnt_q <= resync_cnt_d;
      wait_cnt_q   <= wait_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q     <= backwards;
      wait_q       <= backwards ? '0 : wait_val;
      resynced_q   <= !backwards && late;
      resync_tot_q <= backwards ? resync_cnt_q : resync_cnt_d;
      wait_tot_q   <= backwards ? wait_cnt_q : wait_cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign wait_ns_o      = wait_q;
  assign resynced_o     = resynced_q;
  assign resync_total_o = resync_tot_q;
  assign wait_total_o   = wait_tot_q;

endmodule

// ===== hdl/fdp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fdp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pready,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        status_o,
  input logic [fdp_pkg::TIME_W-1:0]  wait_ns_o,
  input logic                        resynced_o
);
  import fdp_pkg::*;

  logic [TIME_W-1:0] wait_seen;
  assign wait_seen = wait_ns_o;

  // a stalled result keeps its wait value
  `FDP_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, wait_seen)

  // a backwards clock reports neither a wait nor a resync
  `FDP_ASSERT(a_backwards_quiet, clk_i, rst_ni, (out_valid_o && status_o) |-> (wait_seen == '0 && !resynced_o))

  // a resync moves the deadline to now, so there is nothing to wait for
  `FDP_ASSERT(a_resync_no_wait, clk_i, rst_ni, (out_valid_o && resynced_o) |-> (wait_seen == '0 && !status_o))

  // the apb port never inserts wait states
  `FDP_ASSERT(a_pready_high, clk_i, rst_ni, pready)

endmodule

bind frame_deadline_pacer_top fdp_checker u_fdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .wait_ns_o   (wait_ns_o),
  .resynced_o  (resynced_o)
);

// ===== tb/sv/tb_frame_deadline_pacer_top.sv =====
`timescale 1ns / 1ps
module tb_frame_deadline_pacer_top;
  import fdp_pkg::*;

  // register index past the last one, writes there must be ignored
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int unsigned PHASES = 9;
  localparam int unsigned PHASE_EVENTS = 194;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic               status;
    logic [TIME_W-1:0]  wait_ns;
    logic               resynced;
    logic [CNT_W-1:0]   resync_total;
    logic [CNT_W-1:0]   wait_total;
  } pacer_result_t;

  class pacer_scoreboard;
    // shadow configuration
    logic                cfg_unthrottled;
    logic [DATA_W-1:0]   cfg_period;
    logic [DATA_W-1:0]   cfg_rem_step;
    logic [DATA_W-1:0]   cfg_rem_mod;
    logic [LIMIT_W-1:0]  cfg_late;
    // shadow pacer state
    logic                started;
    logic [TIME_W-1:0]   due_ns;
    logic [TIME_W-1:0]   last_ns;
    logic [DATA_W-1:0]   frac_acc;
    logic [CNT_W-1:0]    resync_cnt;
    logic [CNT_W-1:0]    wait_cnt;
    pacer_result_t       expected_q[$];
    int unsigned         mismatches;
    int unsigned         events_seen;
    int unsigned         results_checked;
    int unsigned         resyncs_seen;
    int unsigned         backwards_seen;

    function new();
      cfg_unthrottled = 1'b0;
      cfg_period      = RST_PERIOD;
      cfg_rem_step    = RST_REM_STEP;
      cfg_rem_mod     = RST_REM_MOD;
      cfg_late        = RST_LATE_LIMIT;
      started         = 1'b0;
      due_ns          = '0;
      last_ns         = '0;
      frac_acc        = '0;
      resync_cnt      = '0;
      wait_cnt        = '0;
      mismatches      = 0;
      events_seen     = 0;
      results_checked = 0;
      resyncs_seen    = 0;
      backwards_seen  = 0;
    endfunction

    function void mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_UNTHROTTLED: cfg_unthrottled = data[0];
        REG_PERIOD:      cfg_period      = data;
        REG_REM_STEP:    cfg_rem_step    = data;
        REG_REM_MOD:     cfg_rem_mod     = data;
        REG_LATE_LIMIT:  cfg_late        = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(logic [2:0] idx);
      logic [DATA_W-1:0] v;
      v = '0;
      case (idx)
        REG_UNTHROTTLED: v = DATA_W'(cfg_unthrottled);
        REG_PERIOD:      v = cfg_period;
        REG_REM_STEP:    v = cfg_rem_step;
        REG_REM_MOD:     v = cfg_rem_mod;
        REG_LATE_LIMIT:  v = DATA_W'(cfg_late);
        default: ;
      endcase
      return v;
    endfunction

    function logic [TIME_W-1:0] late_threshold();
      return TIME_W'(cfg_late) * (TIME_W'(cfg_period) + 64'd1);
    endfunction

    // advance the shadow pacer by one accepted event
    function void note_event(logic [TIME_W-1:0] now_ns);
      pacer_result_t r;
      logic [TIME_W-1:0] sum;
      r = '0;
      events_seen++;
      if (started && now_ns < last_ns) begin
        r.status = 1'b1;
      end else begin
        if (!started) begin
          started  = 1'b1;
          due_ns   = now_ns;
          frac_acc = '0;
        end else if (now_ns > due_ns && (now_ns - due_ns) > late_threshold()) begin
          due_ns     = now_ns;
          frac_acc   = '0;
          resync_cnt = resync_cnt + 1'b1;
          r.resynced = 1'b1;
        end
        if (!cfg_unthrottled && now_ns < due_ns) begin
          r.wait_ns = due_ns - now_ns;
          wait_cnt  = wait_cnt + 1'b1;
        end
        last_ns = now_ns;
        due_ns  = due_ns + TIME_W'(cfg_period);
        sum = TIME_W'(frac_acc) + TIME_W'(cfg_rem_step);
        if (sum >= TIME_W'(cfg_rem_mod)) begin
          sum    = sum - TIME_W'(cfg_rem_mod);
          due_ns = due_ns + 64'd1;
        end
        frac_acc = sum[DATA_W-1:0];
      end
      r.resync_total = resync_cnt;
      r.wait_total   = wait_cnt;
      expected_q.push_back(r);
    endfunction

    function void check_result(pacer_result_t got);
      pacer_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatch($sformatf("result with no pending event: status %0d wait %0d resynced %0d",
                           got.status, got.wait_ns, got.resynced));
      end else begin
        exp_r = expected_q.pop_front();
        results_checked++;
        if (got.resynced) resyncs_seen++;
        if (got.status) backwards_seen++;
        if (got !== exp_r)
          mismatch($sformatf({"status %0d/%0d wait %0d/%0d resynced %0d/%0d ",
                              "resync_total %0d/%0d wait_total %0d/%0d (exp/got)"},
                             exp_r.status, got.status, exp_r.wait_ns, got.wait_ns,
                             exp_r.resynced, got.resynced, exp_r.resync_total,
                             got.resync_total, exp_r.wait_total, got.wait_total));
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ADDR_W-1:0]   paddr          = '0;
  logic [DATA_W-1:0]   pwdata         = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [TIME_W-1:0]   now_ns_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                status_o;
  logic [TIME_W-1:0]   wait_ns_o;
  logic                resynced_o;
  logic [CNT_W-1:0]    resync_total_o;
  logic [CNT_W-1:0]    wait_total_o;

  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 82;
  bit          wide_noise  = 1'b0;

  pacer_scoreboard sb = new();

  frame_deadline_pacer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .now_ns_i       (now_ns_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .wait_ns_o      (wait_ns_o),
    .resynced_o     (resynced_o),
    .resync_total_o (resync_total_o),
    .wait_total_o   (wait_total_o)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({status_o, wait_ns_o, resynced_o, resync_total_o, wait_total_o});
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(logic [2:0] idx);
    logic [DATA_W-1:0] got, mask;
    mask = (idx == REG_UNTHROTTLED) ? 32'h1 :
           (idx == REG_LATE_LIMIT)  ? 32'hFF : 32'hFFFF_FFFF;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    if ((got & mask) !== (sb.reg_value(idx) & mask))
      sb.mismatch($sformatf("register %0d read %0h, expected %0h", idx, got & mask,
                            sb.reg_value(idx) & mask));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic u, logic [DATA_W-1:0] per, logic [DATA_W-1:0] st,
                            logic [DATA_W-1:0] md, logic [DATA_W-1:0] lt);
    apb_write(REG_UNTHROTTLED, DATA_W'(u));
    apb_write(REG_PERIOD, per);
    apb_write(REG_REM_STEP, st);
    apb_write(REG_REM_MOD, md);
    apb_write(REG_LATE_LIMIT, lt);
  endtask

  // one frame-ready transaction, valid stays up until the next call or a drain
  task automatic send_event(logic [TIME_W-1:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    now_ns_i   <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(t);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  // mostly well-formed frame times around the deadline, plus some broken ones
  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] last, dl, p, thr, off, t, span;
    int unsigned w;
    last = sb.last_ns;
    dl   = sb.due_ns;
    p    = TIME_W'(sb.cfg_period) + 64'd1;
    thr  = sb.late_threshold();
    w    = $urandom_range(99);
    if (w < 28) begin
      off = rand64() % p;
      t = (off > dl) ? last : dl - off;
    end else if (w < 50) begin
      t = (dl < 64'd8) ? dl : dl + TIME_W'($urandom_range(16)) - 64'd8;
    end else if (w < 65) begin
      t = dl + rand64() % (thr + 64'd1);
    end else if (w < 75) begin
      // straddle the resync threshold
      t = dl + thr - 64'd1 + TIME_W'($urandom_range(2));
    end else if (w < 85) begin
      t = dl + thr + 64'd1 + rand64() % (64'd4 * p);
    end else if (w < 92) begin
      t = last;
    end else if (w < 97) begin
      span = (last < 64'd1000000) ? last : 64'd1000000;
      t = (last == 0) ? last : last - 64'd1 - rand64() % span;
    end else if (wide_noise) begin
      t = rand64();
    end else begin
      t = (last == '1) ? rand64() : rand64() % (last + 64'd1);
    end
    if (w < 92 && t < last) t = last;
    return t;
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset configuration first
    send_event(64'd0);
    send_event(64'd0);
    send_event(sb.due_ns - 64'd100);
    send_event(64'd5);
    send_event(sb.due_ns - 64'd1);
    send_event(64'd500_000_000);
    drain();
    apb_write(REG_UNTHROTTLED, 32'd1);
    send_event(sb.last_ns + 64'd1);
    drain();
    // upper bits of the written values are dropped
    apb_write(REG_UNTHROTTLED, 32'hFFFF_FFFE);
    apb_write(REG_LATE_LIMIT, 32'd0);
    send_event(sb.due_ns + 64'd1);
    drain();
    apb_write(REG_LATE_LIMIT, 32'h0000_01FF);
    apb_write(REG_REM_MOD, 32'd0);
    apb_write(REG_REM_STEP, 32'd0);
    send_event(sb.due_ns - 64'd3);
    send_event(sb.due_ns - 64'd3);
    drain();
    apb_write(REG_REM_STEP, 32'hFFFF_FFFF);
    apb_write(REG_REM_MOD, 32'd5);
    send_event(sb.due_ns);
    send_event(sb.due_ns);
    drain();
    apb_write(REG_PERIOD, 32'd1);
    apb_write(REG_LATE_LIMIT, 32'd1);
    send_event(sb.due_ns + 64'd2);
    send_event(sb.due_ns + 64'd3);
    drain();
    apb_write(REG_UNUSED, $urandom);
    for (int i = 0; i < 5; i++) apb_check(3'(i));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      tx_idle_pct = (ph < 3) ? 11 : (ph < 6) ? 82 : 0;
      rx_idle_pct = (ph < 3) ? 82 : (ph < 6) ? 11 : 0;
      case (ph)
        0: set_config(1'b0, RST_PERIOD, RST_REM_STEP, RST_REM_MOD, RST_LATE_LIMIT);
        1: set_config(1'b0, 32'd1, 32'd0, 32'd1, 32'd1);
        2: set_config(1'b0, 32'd1000, 32'd3, 32'd7, 32'd255);
        3: set_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255);
        5: set_config(1'b0, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'd2);
        7: set_config(1'b0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1);
        8: set_config(1'($urandom_range(1)), $urandom_range(1 << 20, 1), $urandom,
                      $urandom, $urandom_range(255, 1));
        default: set_config(1'($urandom_range(1)), $urandom_range(5000, 1), $urandom,
                            $urandom, $urandom_range(255, 1));
      endcase
      if (ph == PHASES - 1) begin
        // jump into the top half of the time range
        wide_noise = 1'b1;
        send_event({2'b11, 30'($urandom), $urandom});
      end
      for (int n = 0; n < PHASE_EVENTS; n++) send_event(pick_time());
    end

    // closing events at the top of the time range, the deadline wraps
    send_event(64'hFFFF_FFFF_FFFF_FC00);
    send_event(64'hFFFF_FFFF_FFFF_FFFA);
    send_event(64'hFFFF_FFFF_FFFF_FFFF);
    send_event(64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.pending() > 0)
      sb.mismatch($sformatf("%0d events never produced a result", sb.pending()));
    $display("covered %0d frame events, %0d results checked", sb.events_seen,
             sb.results_checked);
    $display("saw %0d resyncs, %0d backwards clocks, %0d mismatches", sb.resyncs_seen,
             sb.backwards_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fdp_pkg.sv
hdl/frame_deadline_pacer_top.sv
hdl/fdp_checker.sv
tb/sv/tb_frame_deadline_pacer_top.sv
